>>> rtl/core/dense_shortest_path_engine_assert.svh
// Assertion macros used by the shortest path engine RTL.
`ifndef DENSE_SHORTEST_PATH_ENGINE_ASSERT_SVH
`define DENSE_SHORTEST_PATH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsp assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define DSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsp assertion failed: next-cycle implication");

`endif

>>> rtl/core/dsp_pkg.sv
// Types and constants shared by the shortest path engine modules.
package dsp_pkg;

  localparam int VID_W            = 6;   // vertex index inside the chain, up to 64 cells
  localparam int VTX_W            = 4;
  localparam int WGT_W            = 16;
  localparam int COST_W           = 20;
  localparam int CNT_W            = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int VCOUNT_LIMIT     = 16;
  localparam logic [COST_W-1:0] COST_MAX   = '1;
  localparam logic [CNT_W-1:0]  VCOUNT_RST = 5'd16;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_VCOUNT = 1'b0,
    REG_TREE   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_SCAN,
    TOK_RELAX
  } tok_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE2,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Word travelling down the cell chain.
  typedef struct packed {
    tok_kind_t          kind;
    logic               found;   // scan: a candidate was picked
    logic [VID_W-1:0]   idx;     // scan: best vertex; relax: settled vertex
    logic [COST_W-1:0]  cost;    // scan: best cost; relax: cost of settled vertex
    logic [VID_W-1:0]   dst;     // relax: neighbor addressed
    logic [WGT_W-1:0]   weight;  // relax: edge weight
  } tok_t;

  typedef struct packed {
    logic               reached;
    logic               visited;
    logic               has_prev;
    logic [VID_W-1:0]   prev;
    logic [COST_W-1:0]  cost;
  } cell_st_t;

  typedef struct packed {
    logic               init;
    logic               src_ok;
    logic [VID_W-1:0]   src;
    logic               shift;
    logic               tree_mode;
    logic [CNT_W-1:0]   n;
  } cell_ctl_t;

endpackage

>>> rtl/core/dsp_adj_mem.sv
// Adjacency weight memory: one write port, one registered read port.
module dsp_adj_mem #(
  parameter int AW = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [dsp_pkg::WGT_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [dsp_pkg::WGT_W-1:0] rdata
);

  logic [dsp_pkg::WGT_W-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dsp_cell.sv
// One vertex cell: holds cost and flags, joins the min scan, relaxes itself.
module dsp_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [dsp_pkg::VID_W-1:0] index,
  input  dsp_pkg::cell_ctl_t        ctl,
  input  dsp_pkg::tok_t             tok_in,
  output dsp_pkg::tok_t             tok_out,
  input  dsp_pkg::cell_st_t         nb_st,
  output dsp_pkg::cell_st_t         st
);

  logic                        active;
  logic                        settle;
  logic                        eff_visited;
  logic                        take;
  logic                        hit;
  logic [dsp_pkg::COST_W:0]    sum;
  logic [dsp_pkg::COST_W-1:0]  cand;
  dsp_pkg::cell_st_t           st_next;
  dsp_pkg::tok_t               tok_next;

  assign active      = index < {1'b0, ctl.n};
  assign settle      = (tok_in.kind == dsp_pkg::TOK_RELAX) && (tok_in.idx == index);
  assign eff_visited = st.visited | settle;

  always_comb begin
    sum  = {1'b0, tok_in.cost} + (dsp_pkg::COST_W + 1)'(tok_in.weight);
    if (ctl.tree_mode) begin
      cand = dsp_pkg::COST_W'(tok_in.weight);
    end else if (sum[dsp_pkg::COST_W]) begin
      cand = dsp_pkg::COST_MAX;
    end else begin
      cand = sum[dsp_pkg::COST_W-1:0];
    end
    take = (tok_in.kind == dsp_pkg::TOK_SCAN) && active && st.reached && !st.visited &&
           (!tok_in.found || (st.cost < tok_in.cost));
    hit  = (tok_in.kind == dsp_pkg::TOK_RELAX) && (tok_in.dst == index) && active &&
           (tok_in.weight != '0) && !eff_visited && (!st.reached || (cand < st.cost));

    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.idx   = index;
      tok_next.cost  = st.cost;
    end

    st_next = st;
    priority if (ctl.init) begin
      st_next.reached  = active && ctl.src_ok && (index == ctl.src);
      st_next.visited  = 1'b0;
      st_next.has_prev = 1'b0;
      st_next.prev     = '0;
      st_next.cost     = '0;
    end else if (ctl.shift) begin
      st_next = nb_st;
    end else begin
      st_next.visited = eff_visited;
      if (hit) begin
        st_next.reached  = 1'b1;
        st_next.has_prev = 1'b1;
        st_next.prev     = tok_in.idx;
        st_next.cost     = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.reached    <= 1'b0;
      st.visited    <= 1'b0;
      st.has_prev   <= 1'b0;
      tok_out.kind  <= dsp_pkg::TOK_NONE;
    end else begin
      st.reached    <= st_next.reached;
      st.visited    <= st_next.visited;
      st.has_prev   <= st_next.has_prev;
      tok_out.kind  <= tok_next.kind;
    end
    st.prev        <= st_next.prev;
    st.cost        <= st_next.cost;
    tok_out.found  <= tok_next.found;
    tok_out.idx    <= tok_next.idx;
    tok_out.cost   <= tok_next.cost;
    tok_out.dst    <= tok_next.dst;
    tok_out.weight <= tok_next.weight;
  end

endmodule

>>> rtl/core/dense_shortest_path_engine.sv
// Top level of the dense shortest path / spanning tree engine.
// Edge words (s_tuser = write) store one weight a cycle; two-way ones stall in ST_WRITE2.
// A clear word, and reset, sweep the adjacency memory one entry a cycle through all
// 2**(2*clog2(MAX_VERTICES)) entries (256 at the default), with s_tready low meanwhile.
// A run word initializes one cell per vertex, then per settled vertex does a minimum scan
// down the cell chain and streams that vertex's matrix row through the chain; a run is
// bounded by the single memory read port and the chain length. Results then shift out
// of cell 0, one vertex per m_tready, in index order with m_tlast on the final vertex;
// no new word is taken meanwhile.
// Registers: 0 vertex_count (byte 0), 1 tree_mode (byte 4).
module dense_shortest_path_engine #(
  parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // from_vertex[3:0], to_vertex[7:4], weight[23:8],
                                // both_ways[24], source_vertex[28:25], zero[31:29]
  input  logic [1:0]  s_tuser,  // action[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // vertex[3:0], prev_vertex[7:4], has_prev[8],
                                // cost[28:9], reachable[29], zero[31:30]
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "dense_shortest_path_engine_assert.svh"

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int AW  = 2 * VW;
  localparam int LIM = (MAX_VERTICES < dsp_pkg::VCOUNT_LIMIT) ? MAX_VERTICES
                                                              : dsp_pkg::VCOUNT_LIMIT;

  // Registers
  logic [dsp_pkg::CNT_W-1:0] vertex_count;
  logic                      tree_mode;
  dsp_pkg::reg_idx_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = dsp_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= dsp_pkg::VCOUNT_RST;
      tree_mode    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        dsp_pkg::REG_VCOUNT: vertex_count <= pwdata[dsp_pkg::CNT_W-1:0];
        dsp_pkg::REG_TREE:   tree_mode    <= pwdata[0];
        default:             tree_mode    <= tree_mode;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dsp_pkg::REG_VCOUNT: prdata = {{(32 - dsp_pkg::CNT_W){1'b0}}, vertex_count};
      dsp_pkg::REG_TREE:   prdata = {31'd0, tree_mode};
      default:             prdata = '0;
    endcase
  end

  // Active vertex count: zero reads as one, large values clamp.
  logic [dsp_pkg::CNT_W-1:0] act_n;
  always_comb begin
    if (vertex_count == '0) begin
      act_n = dsp_pkg::CNT_W'(1);
    end else if (vertex_count > dsp_pkg::CNT_W'(LIM)) begin
      act_n = dsp_pkg::CNT_W'(LIM);
    end else begin
      act_n = vertex_count;
    end
  end

  // Input word fields
  dsp_pkg::action_t            in_action;
  logic [7:0]                  in_from;
  logic [7:0]                  in_to;
  logic [dsp_pkg::WGT_W-1:0]   in_weight;
  logic                        in_both;
  logic [dsp_pkg::VTX_W-1:0]   in_src;
  logic                        edge_ok;

  assign in_action = dsp_pkg::action_t'(s_tuser);
  assign in_from   = {4'd0, s_tdata[3:0]};
  assign in_to     = {4'd0, s_tdata[7:4]};
  assign in_weight = s_tdata[23:8];
  assign in_both   = s_tdata[24];
  assign in_src    = s_tdata[28:25];
  assign edge_ok   = (in_from < 8'(MAX_VERTICES)) && (in_to < 8'(MAX_VERTICES));

  // Control state
  dsp_pkg::state_t            state, state_next;
  logic [AW-1:0]              clr_addr;
  logic [VW-1:0]              rcnt;
  logic                       kick, kick_next;
  logic [dsp_pkg::VID_W-1:0]  u;
  logic [dsp_pkg::COST_W-1:0] u_cost;
  logic                       rd_valid;
  logic [dsp_pkg::VID_W-1:0]  rd_dst;
  logic [dsp_pkg::CNT_W-1:0]  out_cnt;
  logic [AW-1:0]              rev_addr;
  logic [dsp_pkg::WGT_W-1:0]  rev_weight;
  logic [dsp_pkg::VTX_W-1:0]  run_src;

  // Memory port
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [dsp_pkg::WGT_W-1:0]  mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [dsp_pkg::WGT_W-1:0]  mem_rdata;

  // Chain
  dsp_pkg::tok_t              tok_head;
  dsp_pkg::tok_t              tok_q [MAX_VERTICES];
  dsp_pkg::cell_st_t          cst   [MAX_VERTICES];
  dsp_pkg::tok_t              tail_tok;
  dsp_pkg::cell_ctl_t         ctl;
  logic [dsp_pkg::VTX_W-1:0]  src_eff;
  logic                       out_last;

  assign tail_tok  = tok_q[MAX_VERTICES-1];
  assign src_eff   = tree_mode ? '0 : run_src;
  assign out_last  = (out_cnt == act_n - dsp_pkg::CNT_W'(1));
  assign mem_raddr = {u[VW-1:0], rcnt};

  always_comb begin
    state_next    = state;
    kick_next     = 1'b0;
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_addr;
    mem_wdata     = '0;
    ctl.init      = 1'b0;
    ctl.src_ok    = {1'b0, src_eff} < act_n;
    ctl.src       = dsp_pkg::VID_W'(src_eff);
    ctl.shift     = 1'b0;
    ctl.tree_mode = tree_mode;
    ctl.n         = act_n;

    unique case (state)
      dsp_pkg::ST_CLEAR: begin
        // sweep zeros through every entry
        mem_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = dsp_pkg::ST_IDLE;
        end
      end
      dsp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (in_action)
            dsp_pkg::ACT_WRITE: begin
              mem_we    = edge_ok;
              mem_waddr = {in_from[VW-1:0], in_to[VW-1:0]};
              mem_wdata = in_weight;
              if (edge_ok && in_both) begin
                state_next = dsp_pkg::ST_WRITE2;
              end
            end
            dsp_pkg::ACT_CLEAR: state_next = dsp_pkg::ST_CLEAR;
            dsp_pkg::ACT_RUN:   state_next = dsp_pkg::ST_INIT;
            default:            state_next = dsp_pkg::ST_IDLE;
          endcase
        end
      end
      dsp_pkg::ST_WRITE2: begin
        mem_we     = 1'b1;
        mem_waddr  = rev_addr;
        mem_wdata  = rev_weight;
        state_next = dsp_pkg::ST_IDLE;
      end
      dsp_pkg::ST_INIT: begin
        ctl.init   = 1'b1;
        kick_next  = 1'b1;
        state_next = dsp_pkg::ST_SCAN;
      end
      dsp_pkg::ST_SCAN: begin
        if (tail_tok.kind == dsp_pkg::TOK_SCAN) begin
          state_next = tail_tok.found ? dsp_pkg::ST_RELAX : dsp_pkg::ST_OUT;
        end
      end
      dsp_pkg::ST_RELAX: begin
        if (rcnt == VW'(MAX_VERTICES - 1)) begin
          state_next = dsp_pkg::ST_DRAIN;
        end
      end
      dsp_pkg::ST_DRAIN: begin
        // wait for the last row word to leave the chain
        if (tail_tok.kind == dsp_pkg::TOK_RELAX &&
            tail_tok.dst == dsp_pkg::VID_W'(MAX_VERTICES - 1)) begin
          kick_next  = 1'b1;
          state_next = dsp_pkg::ST_SCAN;
        end
      end
      dsp_pkg::ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          ctl.shift = 1'b1;
          if (out_last) begin
            state_next = dsp_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = dsp_pkg::ST_IDLE;
    endcase
  end

  // Chain head: a scan word once per scan, else row words from the memory.
  always_comb begin
    tok_head = '0;
    tok_head.kind = dsp_pkg::TOK_NONE;
    if (state == dsp_pkg::ST_SCAN && kick) begin
      tok_head.kind = dsp_pkg::TOK_SCAN;
    end else if (rd_valid) begin
      tok_head.kind   = dsp_pkg::TOK_RELAX;
      tok_head.idx    = u;
      tok_head.cost   = u_cost;
      tok_head.dst    = rd_dst;
      tok_head.weight = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dsp_pkg::ST_CLEAR;
      clr_addr <= '0;
      kick     <= 1'b0;
      rd_valid <= 1'b0;
      rcnt     <= '0;
      out_cnt  <= '0;
    end else begin
      state    <= state_next;
      kick     <= kick_next;
      rd_valid <= (state == dsp_pkg::ST_RELAX);
      if (state == dsp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      // advance the row read, restart it for each settled vertex
      if (state == dsp_pkg::ST_RELAX) begin
        rcnt <= rcnt + VW'(1);
      end else begin
        rcnt <= '0;
      end
      if (state == dsp_pkg::ST_OUT) begin
        if (m_tready) begin
          out_cnt <= out_cnt + dsp_pkg::CNT_W'(1);
        end
      end else begin
        out_cnt <= '0;
      end
    end
    rd_dst <= dsp_pkg::VID_W'(rcnt);
    if (state == dsp_pkg::ST_SCAN && tail_tok.kind == dsp_pkg::TOK_SCAN) begin
      u      <= tail_tok.idx;
      u_cost <= tail_tok.cost;
    end
    // hold the fields of the word taken in idle for the cycles that follow it
    if (state == dsp_pkg::ST_IDLE) begin
      rev_addr   <= {in_to[VW-1:0], in_from[VW-1:0]};
      rev_weight <= in_weight;
      run_src    <= in_src;
    end
  end

  dsp_adj_mem #(
    .AW(AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    dsp_pkg::tok_t     c_in;
    dsp_pkg::cell_st_t c_nb;
    if (i == 0) begin : g_head
      assign c_in = tok_head;
    end else begin : g_link
      assign c_in = tok_q[i-1];
    end
    if (i == MAX_VERTICES - 1) begin : g_end
      assign c_nb = '0;
    end else begin : g_nb
      assign c_nb = cst[i+1];
    end
    dsp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .index   (dsp_pkg::VID_W'(i)),
      .ctl     (ctl),
      .tok_in  (c_in),
      .tok_out (tok_q[i]),
      .nb_st   (c_nb),
      .st      (cst[i])
    );
  end

  // Result word from cell 0; unreached vertices report zeros but for the vertex index.
  logic hp;
  assign hp       = cst[0].reached && cst[0].has_prev;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00,
                     cst[0].reached,
                     cst[0].reached ? cst[0].cost : {dsp_pkg::COST_W{1'b0}},
                     hp,
                     hp ? cst[0].prev[dsp_pkg::VTX_W-1:0] : {dsp_pkg::VTX_W{1'b0}},
                     out_cnt[dsp_pkg::VTX_W-1:0]};

  `DSP_ASSERT_IMPL(a_in_out_excl, s_tready, !m_tvalid)
  `DSP_ASSERT_NEXT(a_last_frees_input, m_tvalid && m_tready && m_tlast, s_tready)
  `DSP_ASSERT_IMPL(a_scan_pick_active, tail_tok.kind == dsp_pkg::TOK_SCAN && tail_tok.found, tail_tok.idx < {1'b0, act_n})

endmodule

>>> bench/tb.sv
// Testbench for the dense shortest path engine: random graphs, runs and register settings.
`timescale 1ns / 100ps

class path_scoreboard;
  logic [15:0] adj_weight [16][16];
  logic [4:0]  vcount_reg;
  logic        tree_reg;
  logic [31:0] pending_words [$];
  logic        pending_last [$];
  int          fail_count;

  function void reset_model();
    foreach (adj_weight[a, b]) adj_weight[a][b] = '0;
    vcount_reg = 5'd16;
    tree_reg = 1'b0;
  endfunction

  // Apply one accepted input word; a run queues one result per vertex.
  function void note_word(logic [1:0] act, logic [31:0] data);
    logic [3:0] fv, tv, sv;
    logic [15:0] w;
    int n, u, d, i, src;
    logic [19:0] cost [16];
    bit reached [16], visited [16], hasp [16];
    logic [3:0] prv [16];
    logic [20:0] cand;
    logic [31:0] word;
    fv = data[3:0]; tv = data[7:4]; w = data[23:8]; sv = data[28:25];
    if (act == dsp_pkg::ACT_WRITE) begin
      adj_weight[fv][tv] = w;
      if (data[24]) adj_weight[tv][fv] = w;
      return;
    end
    if (act == dsp_pkg::ACT_CLEAR) begin
      foreach (adj_weight[a, b]) adj_weight[a][b] = '0;
      return;
    end
    if (act != dsp_pkg::ACT_RUN) return;
    n = vcount_reg;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    src = tree_reg ? 0 : sv;
    for (i = 0; i < 16; i++) begin
      cost[i] = '0; reached[i] = 0; visited[i] = 0; hasp[i] = 0; prv[i] = '0;
    end
    if (src < n) reached[src] = 1;
    forever begin
      u = n;
      for (i = 0; i < n; i++)
        if (reached[i] && !visited[i] && (u == n || cost[i] < cost[u])) u = i;
      if (u == n) break;
      visited[u] = 1;
      for (d = 0; d < n; d++) begin
        if (adj_weight[u][d] == 0 || visited[d]) continue;
        if (tree_reg) cand = 21'(adj_weight[u][d]);
        else begin
          cand = 21'(cost[u]) + 21'(adj_weight[u][d]);
          if (cand > 21'hFFFFF) cand = 21'hFFFFF;
        end
        if (!reached[d] || cand[19:0] < cost[d]) begin
          cost[d] = cand[19:0]; prv[d] = 4'(u); hasp[d] = 1; reached[d] = 1;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      word = '0;
      word[3:0] = 4'(i);
      if (reached[i] && hasp[i]) begin
        word[7:4] = prv[i]; word[8] = 1'b1;
      end
      if (reached[i]) begin
        word[28:9] = cost[i]; word[29] = 1'b1;
      end
      pending_words.push_back(word);
      pending_last.push_back(i == n - 1);
    end
  endfunction

  function void check_result(logic [31:0] data, logic lst);
    logic [31:0] e;
    logic el;
    if (pending_words.size() == 0) begin
      $error("unexpected result word %h", data);
      fail_count++;
      return;
    end
    e = pending_words.pop_front();
    el = pending_last.pop_front();
    if (data[3:0] !== e[3:0]) begin
      $error("vertex expected %0d actual %0d", e[3:0], data[3:0]); fail_count++;
    end
    if (data[7:4] !== e[7:4]) begin
      $error("prev_vertex expected %0d actual %0d", e[7:4], data[7:4]); fail_count++;
    end
    if (data[8] !== e[8]) begin
      $error("has_prev expected %0d actual %0d", e[8], data[8]); fail_count++;
    end
    if (data[28:9] !== e[28:9]) begin
      $error("cost expected %0d actual %0d", e[28:9], data[28:9]); fail_count++;
    end
    if (data[29] !== e[29]) begin
      $error("reachable expected %0d actual %0d", e[29], data[29]); fail_count++;
    end
    if (lst !== el) begin
      $error("last expected %0d actual %0d", el, lst); fail_count++;
    end
  endfunction
endclass

module tb;
  import dsp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // from[3:0] to[7:4] weight[23:8] both[24] source[28:25]
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // vertex[3:0] prev[7:4] has_prev[8] cost[28:9] reachable[29]
  logic        m_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  path_scoreboard sb;
  bit calm_sink;   // sink stretch with no stalls
  bit calm_src;    // source stretch with no gaps
  int runs_seen;

  dense_shortest_path_engine dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample results at the rising edge; hand them to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tlast);
      if (m_tlast) runs_seen++;
    end
  end

  // Randomize the sink's ready at the falling edge; about 8 in 100 stalls.
  always @(negedge clk) begin
    m_tready <= calm_sink ? 1'b1 : ($urandom_range(99) >= 8);
  end

  // Write one register: setup cycle, then access cycle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(int'(idx) * 4); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_VCOUNT) sb.vcount_reg = value[4:0];
    else sb.tree_reg = value[0];
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Present one word and hold it until accepted; gaps go in before it.
  task automatic send_word(logic [1:0] act, logic [31:0] data);
    while (!calm_src && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1; s_tuser <= act; s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    sb.note_word(act, data);
    @(negedge clk);
  endtask

  task automatic send_edge(int a, int b, int w, bit both);
    logic [31:0] d;
    d = '0;
    d[3:0] = 4'(a); d[7:4] = 4'(b); d[23:8] = 16'(w); d[24] = both;
    send_word(ACT_WRITE, d);
  endtask

  task automatic send_run(int src);
    logic [31:0] d;
    d = $urandom & 32'h00FF_FFFF;   // unused fields carry noise
    d[28:25] = 4'(src);
    send_word(ACT_RUN, d);
  endtask

  // Drop valid, let results drain, then wait out any clear sweep.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic random_graph(int n, int wmax, int density);
    int e;
    for (e = 0; e < density; e++)
      send_edge($urandom_range(n - 1), $urandom_range(n - 1),
                $urandom_range(wmax), $urandom_range(1));
  endtask

  initial begin
    int phase, k, n;
    sb = new();
    sb.reset_model();
    calm_sink = 0; calm_src = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (300) @(negedge clk);   // reset clears the matrix

    // Directed: extremes, every action, the named corner cases.
    send_run(0);                              // empty graph
    send_edge(0, 1, 16'hFFFF, 1);
    send_edge(1, 2, 16'hFFFF, 0);
    send_edge(2, 3, 16'hFFFF, 0);
    send_edge(3, 15, 16'hFFFF, 1);
    send_edge(15, 15, 5, 0);                  // self loop
    send_edge(4, 5, 3, 1);
    send_edge(5, 4, 0, 0);                    // remove one direction
    send_word(ACT_NOP, 32'h1FFF_FFFF);        // ignored action
    send_run(0);                              // chain of max weights
    send_run(15);                             // source at top index
    send_run(4);
    settle();
    write_reg(REG_TREE, 32'd1);
    write_reg(REG_VCOUNT, 32'd0);             // treated as one vertex
    send_run(9);
    settle();
    write_reg(REG_VCOUNT, 32'd31);            // saturates to sixteen
    send_run(3);
    settle();
    write_reg(REG_TREE, 32'd0);
    write_reg(REG_VCOUNT, 32'd4);
    send_run(12);                             // source beyond the count
    send_word(ACT_CLEAR, $urandom);
    send_run(0);
    settle();

    // Random phases over settings; edges far outnumber runs.
    for (phase = 0; phase < 10; phase++) begin
      n = (phase == 0) ? 1 : (phase == 1) ? 16 : $urandom_range(1, 16);
      if (phase % 5 == 2) n = $urandom_range(17, 31);
      write_reg(REG_VCOUNT, n);
      write_reg(REG_TREE, $urandom_range(1));
      calm_src = (phase == 5); calm_sink = (phase == 5);
      if (n > 16) n = 16;
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(3) == 0) send_word(ACT_CLEAR, $urandom);
        random_graph(16, ($urandom_range(1)) ? 65535 : 20, $urandom_range(4, 2 * n + 4));
        if ($urandom_range(9) == 0) send_word(ACT_NOP, $urandom);
        send_run($urandom_range(15));
      end
      settle();
    end
    calm_src = 0; calm_sink = 0;
    settle();
    if (sb.fail_count == 0 && sb.pending_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
